// ===== design/cupmb_pkg.sv =====
// shared types, codes and constants of the coap uri-path message builder
package cupmb_pkg;

  localparam int SEGMENT_DEPTH_DEF = 32;

  // input operation codes
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_URL   = 2'd1;
  localparam logic [1:0] OP_PAY   = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] SLASH_CHAR    = 8'h2F;
  localparam logic [7:0] HDR_VER_BITS  = 8'h40;
  localparam logic [7:0] DELTA_FIRST   = 8'hB0;
  localparam logic [7:0] DELTA_NEXT    = 8'h00;
  localparam logic [3:0] LEN_EXT_NIB   = 4'hD;
  localparam logic [7:0] LEN_EXT_BASE  = 8'd13;
  localparam logic [7:0] PAYLOAD_MARK  = 8'hFF;
  localparam logic [15:0] LEN_MAX      = 16'hFFFF;
  localparam logic [1:0] HDR_LAST      = 2'd3;

  // which result the datapath builds
  typedef enum logic [3:0] {
    R_HDR,
    R_OPT,
    R_EXT,
    R_DATA,
    R_ERR,
    R_MARK,
    R_PAY,
    R_DONE,
    R_NONE
  } sel_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    sel_t       sel;
    logic [1:0] hdr_idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic payload_started;
    logic overflow;
    logic cnt_zero;
    logic cnt_ext;
    logic idx_last;
  } sts_t;

endpackage

// ===== design/cupmb_ram.sv =====
// generic single write, single registered read ram
module cupmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/cupmb_dpath.sv =====
// datapath: message state registers, segment store and output register
module cupmb_dpath #(
  parameter int SEGMENT_DEPTH = cupmb_pkg::SEGMENT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cupmb_pkg::cmd_t   cmd,
  output cupmb_pkg::sts_t   sts,
  input  logic [1:0]        operation,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        msg_type,
  input  logic [7:0]        method_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        result_kind,
  output logic [15:0]       result_value,
  output logic              last_of_run
);
  import cupmb_pkg::*;

  localparam int IDX_W = $clog2(SEGMENT_DEPTH);
  localparam int CNT_W = $clog2(SEGMENT_DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic             first_pending;
  logic             payload_started;
  logic             overflow;
  logic [15:0]      message_id;
  logic [15:0]      message_length;
  logic [1:0]       type_reg;
  logic [7:0]       method_reg;
  logic [7:0]       byte_reg;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  logic             store_en;
  logic             has_room;
  logic [7:0]       rd_data;
  logic [7:0]       delta;
  logic [7:0]       res_byte;
  logic [1:0]       res_kind;
  logic             is_byte;
  logic             data_done;

  assign has_room  = count < CNT_W'(SEGMENT_DEPTH);
  assign store_en  = cmd.accept && (operation == OP_URL) && !payload_started &&
                     (byte_value != SLASH_CHAR) && has_room;
  assign data_done = cmd.emit && (cmd.sel == R_DATA) && sts.idx_last;

  always_comb begin
    if (cmd.sel != R_DATA || data_done) begin
      idx_next = '0;
    end else if (cmd.emit) begin
      idx_next = idx + IDX_W'(1);
    end else begin
      idx_next = idx;
    end
  end

  cupmb_ram #(
    .WIDTH(8),
    .DEPTH(SEGMENT_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_en),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data(byte_value),
    .rd_addr(idx_next),
    .rd_data(rd_data)
  );

  assign delta = first_pending ? DELTA_FIRST : DELTA_NEXT;

  // result byte and kind for the selected result
  always_comb begin
    res_byte = '0;
    res_kind = KIND_BYTE;
    is_byte  = 1'b1;
    case (cmd.sel)
      R_HDR: begin
        case (cmd.hdr_idx)
          2'd0:    res_byte = HDR_VER_BITS | {2'b00, type_reg, 4'h0};
          2'd1:    res_byte = method_reg;
          2'd2:    res_byte = message_id[15:8];
          default: res_byte = message_id[7:0];
        endcase
      end
      R_OPT: begin
        if (sts.cnt_ext) begin
          res_byte = {delta[7:4], LEN_EXT_NIB};
        end else begin
          res_byte = {delta[7:4], count[3:0]};
        end
      end
      R_EXT:  res_byte = 8'(count) - LEN_EXT_BASE;
      R_DATA: res_byte = rd_data;
      R_MARK: res_byte = PAYLOAD_MARK;
      R_PAY:  res_byte = byte_reg;
      R_ERR: begin
        res_kind = KIND_ERR;
        is_byte  = 1'b0;
      end
      R_DONE: begin
        res_kind = KIND_DONE;
        is_byte  = 1'b0;
      end
      default: is_byte = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      first_pending   <= 1'b1;
      payload_started <= 1'b0;
      overflow        <= 1'b0;
      message_id      <= '0;
      message_length  <= '0;
      out_valid       <= 1'b0;
      idx             <= '0;
    end else begin
      idx <= idx_next;
      if (cmd.accept) begin
        if (operation == OP_BEGIN) begin
          count           <= '0;
          first_pending   <= 1'b1;
          payload_started <= 1'b0;
          overflow        <= 1'b0;
          message_length  <= '0;
        end else if (store_en) begin
          count <= count + CNT_W'(1);
        end else if ((operation == OP_URL) && !payload_started &&
                     (byte_value != SLASH_CHAR)) begin
          overflow <= 1'b1;
        end
      end
      if (cmd.emit) begin
        if (is_byte && message_length != LEN_MAX) begin
          message_length <= message_length + 16'd1;
        end
        if (cmd.sel == R_HDR && cmd.hdr_idx == HDR_LAST) begin
          message_id <= message_id + 16'd1;
        end
        if (cmd.sel == R_MARK) begin
          payload_started <= 1'b1;
        end
        if (cmd.sel == R_ERR) begin
          count    <= '0;
          overflow <= 1'b0;
        end
        if (data_done) begin
          count         <= '0;
          first_pending <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input payload latches and output payload register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      type_reg   <= msg_type;
      method_reg <= method_code;
      byte_reg   <= byte_value;
    end
    if (cmd.emit) begin
      result_kind  <= res_kind;
      result_value <= (cmd.sel == R_DONE) ? message_length : {8'h00, res_byte};
      last_of_run  <= cmd.last;
    end
  end

  assign sts.slot_free       = !out_valid || !out_stall;
  assign sts.payload_started = payload_started;
  assign sts.overflow        = overflow;
  assign sts.cnt_zero        = (count == '0);
  assign sts.cnt_ext         = (count >= CNT_W'(13));
  assign sts.idx_last        = ((CNT_W'(idx) + CNT_W'(1)) == count);

endmodule

// ===== design/cupmb_ctrl.sv =====
// controller: sequences the result beats of each accepted item
module cupmb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      operation,
  input  logic [7:0]      byte_value,
  input  cupmb_pkg::sts_t sts,
  output cupmb_pkg::cmd_t cmd
);
  import cupmb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR,
    S_OPT,
    S_EXT,
    S_DATA,
    S_ERR,
    S_MARK,
    S_PAY,
    S_DONE
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;
  logic [1:0] hcnt;
  logic       accept;
  state_t     after_new;
  state_t     after_cur;
  state_t     close_tgt;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // where to go once the segment is closed
  always_comb begin
    case (operation)
      OP_PAY:  after_new = S_MARK;
      OP_END:  after_new = S_DONE;
      default: after_new = S_IDLE;
    endcase
    case (op)
      OP_PAY:  after_cur = S_MARK;
      OP_END:  after_cur = S_DONE;
      default: after_cur = S_IDLE;
    endcase
    if (sts.overflow) begin
      close_tgt = S_ERR;
    end else if (!sts.cnt_zero) begin
      close_tgt = S_OPT;
    end else begin
      close_tgt = after_new;
    end
  end

  always_comb begin
    cmd.accept  = accept;
    cmd.emit    = (state != S_IDLE) && sts.slot_free;
    cmd.hdr_idx = hcnt;
    cmd.last    = 1'b0;
    cmd.sel     = R_NONE;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_BEGIN: state_next = S_HDR;
            OP_URL: begin
              if (!sts.payload_started && byte_value == SLASH_CHAR) begin
                state_next = close_tgt;
              end
            end
            default: begin
              // once payload has started the marker is not repeated
              if (!sts.payload_started) begin
                state_next = close_tgt;
              end else if (operation == OP_PAY) begin
                state_next = S_PAY;
              end else begin
                state_next = S_DONE;
              end
            end
          endcase
        end
      end
      S_HDR: begin
        cmd.sel  = R_HDR;
        cmd.last = (hcnt == HDR_LAST);
        if (cmd.emit && hcnt == HDR_LAST) state_next = S_IDLE;
      end
      S_OPT: begin
        cmd.sel = R_OPT;
        if (cmd.emit) state_next = sts.cnt_ext ? S_EXT : S_DATA;
      end
      S_EXT: begin
        cmd.sel = R_EXT;
        if (cmd.emit) state_next = S_DATA;
      end
      S_DATA: begin
        cmd.sel  = R_DATA;
        cmd.last = sts.idx_last && (op == OP_URL);
        if (cmd.emit && sts.idx_last) state_next = after_cur;
      end
      S_ERR: begin
        cmd.sel  = R_ERR;
        cmd.last = (op == OP_URL);
        if (cmd.emit) state_next = after_cur;
      end
      S_MARK: begin
        cmd.sel = R_MARK;
        if (cmd.emit) state_next = S_PAY;
      end
      S_PAY: begin
        cmd.sel  = R_PAY;
        cmd.last = 1'b1;
        if (cmd.emit) state_next = S_IDLE;
      end
      S_DONE: begin
        cmd.sel  = R_DONE;
        cmd.last = 1'b1;
        if (cmd.emit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_BEGIN;
      hcnt  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        op   <= operation;
        hcnt <= '0;
      end else if (state == S_HDR && cmd.emit) begin
        hcnt <= hcnt + 2'd1;
      end
    end
  end

endmodule

// ===== design/coap_uri_path_message_builder.sv =====
// top level of the coap uri-path message builder
//
// streams a coap message one byte beat at a time. a begin item gives four
// header beats (version 1 with type, method code, message id high then low);
// url bytes are held in a segment store of SEGMENT_DEPTH bytes, and a '/',
// the first payload byte or the end item turns a non-empty segment into one
// uri-path option (option byte, extension byte for lengths of 13 and up, then
// the segment bytes). a segment that overflows the store gives one error beat
// instead. the first payload byte is preceded by a 0xff marker beat, and the
// end item gives a done beat carrying the message length, saturated at 65535.
// last_of_run marks the final beat caused by an item.
// rate: items are taken one at a time; the input is stalled from the accept of
// an item until its last beat is issued. an item that makes no beat (a plain url
// byte, an empty-segment '/', a url byte after payload) does not stall the input.
// beats go out one per cycle while the output is not stalled, paced by the
// controller's beat sequencer and the single read port of the segment store
// (a segment of L bytes flushes in L + 1 or L + 2 beats).
// there is no clearing pass after reset.
module coap_uri_path_message_builder #(
  parameter int SEGMENT_DEPTH = cupmb_pkg::SEGMENT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  byte_value,
  input  logic [1:0]  msg_type,
  input  logic [7:0]  method_code,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [15:0] result_value,
  output logic        last_of_run
);
  import cupmb_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decides the beats of each item
  cupmb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .byte_value(byte_value),
    .sts       (sts),
    .cmd       (cmd)
  );

  // message state, segment store and registered output beat
  cupmb_dpath #(
    .SEGMENT_DEPTH(SEGMENT_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (operation),
    .byte_value  (byte_value),
    .msg_type    (msg_type),
    .method_code (method_code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .result_value(result_value),
    .last_of_run (last_of_run)
  );

endmodule

// ===== dv/coap_uri_path_message_builder_tb.sv =====
// self-checking testbench for the coap uri-path message builder
`timescale 1ns / 100ps

module coap_uri_path_message_builder_tb;
  import cupmb_pkg::*;

  localparam int SEG_DEPTH    = SEGMENT_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE_BEATS = 16;   // idle cycles after the expected beats are out, for stray beats to show
  localparam int TAIL_CYCLES  = 64;   // quiet time at the end for stray beats

  // one result beat as the block should present it
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } beat_t;

  // scoreboard: tracks the message state of the block and holds the beats
  // each accepted item must produce, in order
  class coap_msg_scoreboard;
    logic [7:0]  seg_bytes [SEG_DEPTH];
    int unsigned seg_len;
    bit          first_opt;
    bit          pay_on;
    bit          seg_ovf;
    logic [15:0] msg_id;
    logic [15:0] msg_len;
    beat_t       want_beats[$];
    beat_t       item_beats[$];
    int          fails;
    int          beats_seen;
    int          dones_seen;
    int          errs_seen;
    int          msgs_begun;

    function new();
      seg_len    = 0;
      first_opt  = 1'b1;
      pay_on     = 1'b0;
      seg_ovf    = 1'b0;
      msg_id     = '0;
      msg_len    = '0;
      fails      = 0;
      beats_seen = 0;
      dones_seen = 0;
      errs_seen  = 0;
      msgs_begun = 0;
    endfunction

    function void add_beat(logic [1:0] kind, logic [15:0] value);
      beat_t b;
      b.kind  = kind;
      b.value = value;
      b.last  = 1'b0;
      item_beats.push_back(b);
    endfunction

    // a byte of the message itself counts toward the length
    function void add_msg_byte(logic [7:0] val);
      if (msg_len != LEN_MAX) msg_len++;
      add_beat(KIND_BYTE, {8'h00, val});
    endfunction

    // turn the buffered segment into a uri-path option, or an error beat
    function void flush_segment();
      logic [7:0] delta;
      if (seg_ovf) begin
        add_beat(KIND_ERR, 16'h0000);
      end else if (seg_len > 0) begin
        delta = first_opt ? DELTA_FIRST : DELTA_NEXT;
        if (seg_len < LEN_EXT_BASE) begin
          add_msg_byte(delta | 8'(seg_len));
        end else begin
          add_msg_byte(delta | {4'h0, LEN_EXT_NIB});
          add_msg_byte(8'(seg_len) - LEN_EXT_BASE);
        end
        for (int i = 0; i < seg_len; i++) add_msg_byte(seg_bytes[i]);
        first_opt = 1'b0;
      end
      seg_len = 0;
      seg_ovf = 1'b0;
    endfunction

    // note an accepted input beat; returns 1 when the block ignores it
    function bit note_item(logic [1:0] op, logic [7:0] val, logic [1:0] mtype,
                           logic [7:0] mcode);
      bit ignored;
      ignored = 1'b0;
      item_beats.delete();
      case (op)
        OP_BEGIN: begin
          msg_len   = '0;
          seg_len   = 0;
          first_opt = 1'b1;
          pay_on    = 1'b0;
          seg_ovf   = 1'b0;
          add_msg_byte(HDR_VER_BITS | {2'b00, mtype, 4'h0});
          add_msg_byte(mcode);
          add_msg_byte(msg_id[15:8]);
          add_msg_byte(msg_id[7:0]);
          msg_id++;
          msgs_begun++;
        end
        OP_URL: begin
          if (pay_on) begin
            ignored = 1'b1;
          end else if (val == SLASH_CHAR) begin
            flush_segment();
          end else if (seg_len < SEG_DEPTH) begin
            seg_bytes[seg_len] = val;
            seg_len++;
          end else begin
            seg_ovf = 1'b1;
          end
        end
        OP_PAY: begin
          if (!pay_on) begin
            flush_segment();
            add_msg_byte(PAYLOAD_MARK);
            pay_on = 1'b1;
          end
          add_msg_byte(val);
        end
        default: begin
          if (!pay_on) flush_segment();
          add_beat(KIND_DONE, msg_len);
        end
      endcase
      if (item_beats.size() > 0) item_beats[item_beats.size() - 1].last = 1'b1;
      foreach (item_beats[i]) want_beats.push_back(item_beats[i]);
      return ignored;
    endfunction

    function void report_fail(string what);
      fails++;
      if (fails <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    // compare an accepted result beat with the oldest expected one
    function void check_beat(logic [1:0] kind, logic [15:0] value, logic last);
      beat_t w;
      beats_seen++;
      if (kind == KIND_DONE) dones_seen++;
      if (kind == KIND_ERR) errs_seen++;
      if (want_beats.size() == 0) begin
        report_fail($sformatf("unexpected beat kind=%0d value=%04h last=%0b",
                              kind, value, last));
        return;
      end
      w = want_beats.pop_front();
      if (w.kind !== kind || w.value !== value || w.last !== last)
        report_fail($sformatf(
          "beat %0d: want kind=%0d value=%04h last=%0b, got kind=%0d value=%04h last=%0b",
          beats_seen, w.kind, w.value, w.last, kind, value, last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_BEGIN;
  logic [7:0]  byte_value = 8'h00;
  logic [1:0]  msg_type = 2'd0;
  logic [7:0]  method_code = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] result_value;
  logic        last_of_run;

  coap_msg_scoreboard sb = new();

  int gap_pct   = 0;   // chance in percent that the sender idles before a beat
  int stall_pct = 0;   // chance in percent that the receiver starts a stall
  int stall_left = 0;
  int items_sent = 0;

  coap_uri_path_message_builder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .byte_value   (byte_value),
    .msg_type     (msg_type),
    .method_code  (method_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .result_value (result_value),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // idle length: mostly none, short gaps, now and then a long one
  function automatic int pick_hold(int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // result side: check every accepted beat, then decide the next stall
  always @(posedge clk) begin : result_side
    int hold;
    if (!rst && out_valid && !out_stall)
      sb.check_beat(result_kind, result_value, last_of_run);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      hold = pick_hold(stall_pct);
      out_stall  <= (hold > 0);
      stall_left <= (hold > 0) ? hold - 1 : 0;
    end
  end

  // present one input beat, hold it until accepted, then tell the scoreboard
  task automatic send_item(input logic [1:0] op, input logic [7:0] val,
                           input logic [1:0] mtype, input logic [7:0] mcode);
    int gap;
    bit ignored;
    gap = pick_hold(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    byte_value  <= val;
    msg_type    <= mtype;
    method_code <= mcode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ignored = sb.note_item(op, val, mtype, mcode);
    if (!ignored) items_sent++;
  endtask

  // unused fields get random values so their bits toggle too
  task automatic send_url(input logic [7:0] val);
    send_item(OP_URL, val, 2'($urandom), 8'($urandom));
  endtask

  task automatic send_pay(input logic [7:0] val);
    send_item(OP_PAY, val, 2'($urandom), 8'($urandom));
  endtask

  task automatic send_begin(input logic [1:0] mtype, input logic [7:0] mcode);
    send_item(OP_BEGIN, 8'($urandom), mtype, mcode);
  endtask

  task automatic send_end();
    send_item(OP_END, 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // stop sending and wait until every expected beat is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.want_beats.size() > 0) @(posedge clk);
    repeat (SETTLE_BEATS) @(posedge clk);
  endtask

  // any url byte except the separator
  function automatic logic [7:0] path_char();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == SLASH_CHAR);
    return v;
  endfunction

  // segment lengths lean to short ones, with the 13-byte extension edge,
  // a full store and an overflowing segment mixed in
  function automatic int pick_seg_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(SEG_DEPTH + 1, SEG_DEPTH + 3);
    if (r < 10) return SEG_DEPTH;
    if (r < 22) return $urandom_range(12, 14);
    if (r < 30) return 0;
    return $urandom_range(1, 11);
  endfunction

  // one well-formed message with random content; forced_len < 0 means free
  task automatic random_message(input int forced_len);
    int nseg;
    int seg_len;
    int npay;
    if ($urandom_range(0, 3) == 0) begin
      gap_pct   = 0;
      stall_pct = 0;
    end else begin
      gap_pct   = $urandom_range(5, 40);
      stall_pct = $urandom_range(5, 40);
    end
    send_begin(2'($urandom), 8'($urandom));
    nseg = $urandom_range(0, 3);
    if (forced_len >= 0 && nseg == 0) nseg = 1;
    if ($urandom_range(0, 3) == 0) send_url(SLASH_CHAR);
    for (int s = 0; s < nseg; s++) begin
      seg_len = (s == 0 && forced_len >= 0) ? forced_len : pick_seg_len();
      repeat (seg_len) send_url(path_char());
      // separators between segments, sometimes a trailing one
      if (s < nseg - 1 || $urandom_range(0, 2) == 0) send_url(SLASH_CHAR);
    end
    if ($urandom_range(0, 1) == 0) begin
      npay = $urandom_range(1, 6);
      repeat (npay) send_pay(8'($urandom));
      // a stray url byte after payload is dropped by the block
      if ($urandom_range(0, 4) == 0) send_url(8'($urandom));
    end
    send_end();
    if ($urandom_range(0, 9) == 0) send_end();
  endtask

  initial begin : stimulus
    int forced[4] = '{12, 13, SEG_DEPTH, SEG_DEPTH + 1};
    int msg_no;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, light idling on both sides
    gap_pct   = 20;
    stall_pct = 20;
    // items before any begin carry on from the reset state
    send_url(8'h78);
    send_end();
    send_end();                              // repeated end reports length again
    send_begin(2'd0, 8'h00);
    send_begin(2'd3, 8'hFF);                 // back to back begins bump the id
    send_url(SLASH_CHAR);                    // empty segment gives nothing
    send_url(8'h00);
    send_url(8'hFF);
    send_url(SLASH_CHAR);
    send_url(SLASH_CHAR);                    // trailing separator adds nothing
    send_url(8'h61);
    send_pay(8'h00);                         // first payload closes the segment
    send_url(8'h55);                         // url after payload is ignored
    send_pay(8'hFF);
    send_end();
    send_begin(2'd1, 8'h45);
    send_url(8'h71);
    send_end();                              // end closes the open segment
    send_begin(2'd2, 8'h02);
    send_pay(8'h80);                         // payload with no path at all
    send_end();
    wait_drained();

    // random part: whole messages, the first few forced onto segment edges,
    // with a sprinkling of random noise items and full drains
    items_sent = 0;
    msg_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (msg_no >= 4 && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
      end else begin
        random_message(msg_no < 4 ? forced[msg_no] : -1);
        msg_no++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d messages and %0d checked beats (%0d done, %0d error)",
             sb.msgs_begun, sb.beats_seen, sb.dones_seen, sb.errs_seen);
    $display("including segment length edges, overflowing segments and stray items");
    if (sb.fails == 0 && sb.want_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches in total", sb.fails);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cupmb_pkg.sv
design/cupmb_ram.sv
design/cupmb_dpath.sv
design/cupmb_ctrl.sv
design/coap_uri_path_message_builder.sv
dv/coap_uri_path_message_builder_tb.sv
